// ----- sv/fmcr_pkg.sv -----
// ----------------------------------------------------------------------------
// fmcr_pkg
// Shared sizes, byte codes and state encoding of the framed memory
// command responder.
// ----------------------------------------------------------------------------
package fmcr_pkg;

  localparam int unsigned DATA_MAX       = 32;
  localparam int unsigned MEMORY_DEPTH   = 64;
  localparam int unsigned FUNCTION_SLOTS = 16;

  localparam int unsigned BUF_AW = (DATA_MAX > 1) ? $clog2(DATA_MAX) : 1;
  localparam int unsigned MEM_AW = (MEMORY_DEPTH > 1) ? $clog2(MEMORY_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DATA_MAX + 1);

  localparam logic [7:0] FRAME_OPEN  = 8'h5B;  // '['
  localparam logic [7:0] FRAME_CLOSE = 8'h5D;  // ']'
  localparam logic [7:0] REPLY_OPEN  = 8'h7B;  // '{'
  localparam logic [7:0] REPLY_CLOSE = 8'h7D;  // '}'
  localparam logic [7:0] SUM_GOOD    = 8'hFF;
  localparam logic [7:0] OUT_OF_RANGE = 8'hFF;
  localparam logic [7:0] HEAD_BYTES  = 8'd6;

  typedef enum logic [2:0] {
    REG_READ_OP   = 3'd0,
    REG_WRITE_OP  = 3'd1,
    REG_CALL_OP   = 3'd2,
    REG_ERROR_OP  = 3'd3,
    REG_BAD_PARAM = 3'd4,
    REG_UNK_FUNC  = 3'd5
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_HUNT, ST_LEN, ST_ID, ST_CMD, ST_DATA, ST_SUM, ST_END,
    ST_WR_A, ST_WR_B, ST_WR_C,
    ST_OPEN, ST_RLEN, ST_RID, ST_RCMD,
    ST_RD_BUF, ST_RD_MEM, ST_RD_OUT, ST_CODE, ST_CSUM, ST_CLOSE
  } state_e;

endpackage

// ----- sv/fmcr_ram.sv -----
// ----------------------------------------------------------------------------
// fmcr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fmcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- sv/framed_memory_command_responder.sv -----
// ----------------------------------------------------------------------------
// framed_memory_command_responder
// Parses '['-framed command frames from a byte stream and answers with
// '{'-framed replies built from a data buffer and a byte memory.
// ----------------------------------------------------------------------------
// Usage: received bytes enter on the s_axis channel, one beat per byte, with
// tuser set when the inter-byte gap expired (the frame is dropped and the byte
// ignored). While a frame is parsed every beat is taken at once. After a
// good closing byte the block drops s_axis_tready and runs the command:
// a write steps through ST_WR_A, ST_WR_B and ST_WR_C for each address/value
// pair, a reply is sent on m_axis at one byte per cycle for header and trailer
// bytes, and each read byte passes ST_RD_BUF, ST_RD_MEM and ST_RD_OUT, bound
// by the buffer RAM and memory RAM reads in series. tlast marks the closing
// '}' of each reply. A reply holds at most DATA_MAX+6 bytes. When the receiver
// stalls, the output register holds its beat and the command engine waits;
// input stays blocked until the reply has been handed to the output register.
// Configuration writes on the cfg channel are always taken (cfg_ready_o=1)
// and must only be issued while the block is idle.
// Reset returns the parser to hunting for '[', loads the default opcodes and
// marks every memory cell as zero through per-cell valid bits; no clearing
// pass is needed.
// ----------------------------------------------------------------------------
module framed_memory_command_responder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
  input  logic       s_axis_tuser,   // [0] gap_timeout
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] tx_byte
  output logic       m_axis_tlast,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);
  import fmcr_pkg::*;

  state_e state_q, state_d;
  logic [7:0] len_q, len_d, id_q, id_d, cmd_q, cmd_d, sum_q, sum_d;
  logic [7:0] first_q, first_d, ck_q, ck_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [5:0] idx_q, idx_d;
  logic [7:0] rep_n_q, rep_n_d, rep_cmd_q, rep_cmd_d, code_q, code_d;
  logic rep_rd_q, rep_rd_d, oor_q, oor_d;
  logic [MEM_AW-1:0] maddr_q, maddr_d;
  logic [MEM_AW-1:0] waddr_q, waddr_d;
  logic [MEMORY_DEPTH-1:0] mvld_q, mvld_d;
  logic [7:0] rd_op_q, wr_op_q, call_op_q, err_op_q, bad_q, unk_q;
  logic       tvalid_q, tlast_q;
  logic [7:0] tdata_q;

  logic             buf_we;
  logic [BUF_AW-1:0] buf_waddr, buf_raddr;
  logic [7:0]       buf_rdata, mem_rdata;
  logic             mem_we;
  logic [MEM_AW-1:0] mem_raddr;

  logic       acc, out_free, emit, emit_last, waddr_ok;
  logic [7:0] c, emit_byte, mem_byte;

  assign c             = s_axis_tdata;
  assign s_axis_tready = (state_q == ST_HUNT) || (state_q == ST_LEN) ||
                         (state_q == ST_ID) || (state_q == ST_CMD) ||
                         (state_q == ST_DATA) || (state_q == ST_SUM) ||
                         (state_q == ST_END);
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign out_free      = !tvalid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign mem_byte      = oor_q ? OUT_OF_RANGE : (mvld_q[maddr_q] ? mem_rdata : 8'd0);
  assign waddr_ok      = {1'b0, buf_rdata} < 9'(MEMORY_DEPTH);

  fmcr_ram #(.WIDTH(8), .DEPTH(DATA_MAX)) u_buf (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (c),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  fmcr_ram #(.WIDTH(8), .DEPTH(MEMORY_DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (waddr_q),
    .wdata_i (buf_rdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d = state_q; len_d = len_q; id_d = id_q; cmd_d = cmd_q; sum_d = sum_q;
    first_d = first_q; ck_d = ck_q; cnt_d = cnt_q; idx_d = idx_q;
    rep_n_d = rep_n_q; rep_cmd_d = rep_cmd_q; code_d = code_q; rep_rd_d = rep_rd_q;
    oor_d = oor_q; maddr_d = maddr_q; waddr_d = waddr_q; mvld_d = mvld_q;
    buf_we = 1'b0; buf_waddr = cnt_q[BUF_AW-1:0]; buf_raddr = idx_q[BUF_AW-1:0];
    mem_we = 1'b0; mem_raddr = buf_rdata[MEM_AW-1:0];
    emit = 1'b0; emit_byte = 8'd0; emit_last = 1'b0;

    unique case (state_q)
      ST_HUNT: begin
        if (acc && !s_axis_tuser && c == FRAME_OPEN) state_d = ST_LEN;
      end
      ST_LEN: begin
        if (acc) begin
          len_d = (c >= HEAD_BYTES) ? c - HEAD_BYTES : 8'd0;
          sum_d = c;
          state_d = ST_ID;
        end
      end
      ST_ID: begin
        if (acc) begin
          id_d = c; sum_d = sum_q + c; state_d = ST_CMD;
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd_d = c; sum_d = sum_q + c; cnt_d = '0;
          state_d = (len_q == 8'd0) ? ST_SUM : ST_DATA;
        end
      end
      ST_DATA: begin
        if (acc) begin
          if (32'(cnt_q) >= DATA_MAX) begin
            state_d = ST_HUNT;
          end else begin
            buf_we = 1'b1;
            if (cnt_q == '0) first_d = c;
            sum_d = sum_q + c;
            cnt_d = cnt_q + 1'b1;
            if (8'(cnt_d) >= len_q) state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (acc) begin
          sum_d = sum_q + c; state_d = ST_END;
        end
      end
      ST_END: begin
        if (acc) begin
          state_d = ST_HUNT;
          idx_d = '0;
          if (c == FRAME_CLOSE && sum_q == SUM_GOOD) begin
            rep_rd_d = 1'b0;
            rep_n_d = 8'd1;
            rep_cmd_d = err_op_q;
            code_d = bad_q;
            if (cmd_q == rd_op_q) begin
              if (id_q != 8'd0) begin
                state_d = ST_OPEN;
                if (len_q != 8'd0) begin
                  rep_rd_d = 1'b1; rep_n_d = len_q; rep_cmd_d = rd_op_q;
                end
              end
            end else if (cmd_q == wr_op_q) begin
              if (len_q == 8'd0 || len_q[0]) begin
                if (id_q != 8'd0) state_d = ST_OPEN;
              end else begin
                code_d = 8'd0;
                state_d = ST_WR_A;
              end
            end else if (cmd_q == call_op_q) begin
              if (id_q != 8'd0) begin
                state_d = ST_OPEN;
                if (len_q != 8'd0 && 32'(first_q) < FUNCTION_SLOTS) code_d = unk_q;
              end
            end
          end
        end
      end
      ST_WR_A: state_d = ST_WR_B;
      ST_WR_B: begin
        waddr_d = buf_rdata[MEM_AW-1:0];
        oor_d = !waddr_ok;
        buf_raddr = BUF_AW'(idx_q + 6'd1);
        state_d = ST_WR_C;
      end
      ST_WR_C: begin
        if (!oor_q) begin
          mem_we = 1'b1;
          mvld_d[waddr_q] = 1'b1;
          code_d = code_q + 8'd1;
        end
        idx_d = idx_q + 6'd2;
        if (8'(idx_d) + 8'd1 >= len_q) begin
          if (id_q != 8'd0) begin
            rep_n_d = 8'd1; rep_cmd_d = wr_op_q; state_d = ST_OPEN;
          end else begin
            state_d = ST_HUNT;
          end
        end else begin
          state_d = ST_WR_A;
        end
      end
      ST_OPEN: begin
        emit = 1'b1; emit_byte = REPLY_OPEN;
        if (out_free) begin
          idx_d = '0; state_d = ST_RLEN;
        end
      end
      ST_RLEN: begin
        emit = 1'b1; emit_byte = HEAD_BYTES + rep_n_q;
        if (out_free) begin
          ck_d = emit_byte; state_d = ST_RID;
        end
      end
      ST_RID: begin
        emit = 1'b1; emit_byte = id_q;
        if (out_free) begin
          ck_d = ck_q + id_q; state_d = ST_RCMD;
        end
      end
      ST_RCMD: begin
        emit = 1'b1; emit_byte = rep_cmd_q;
        if (out_free) begin
          ck_d = ck_q + rep_cmd_q;
          state_d = rep_rd_q ? ST_RD_BUF : ST_CODE;
        end
      end
      ST_RD_BUF: state_d = ST_RD_MEM;
      ST_RD_MEM: begin
        oor_d = !waddr_ok;
        maddr_d = buf_rdata[MEM_AW-1:0];
        state_d = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        emit = 1'b1; emit_byte = mem_byte;
        if (out_free) begin
          ck_d = ck_q + mem_byte;
          idx_d = idx_q + 6'd1;
          state_d = (8'(idx_d) >= rep_n_q) ? ST_CSUM : ST_RD_BUF;
        end
      end
      ST_CODE: begin
        emit = 1'b1; emit_byte = code_q;
        if (out_free) begin
          ck_d = ck_q + code_q; state_d = ST_CSUM;
        end
      end
      ST_CSUM: begin
        emit = 1'b1; emit_byte = SUM_GOOD - ck_q;
        if (out_free) state_d = ST_CLOSE;
      end
      ST_CLOSE: begin
        emit = 1'b1; emit_byte = REPLY_CLOSE; emit_last = 1'b1;
        if (out_free) state_d = ST_HUNT;
      end
      default: state_d = ST_HUNT;
    endcase

    // A gap timeout drops any frame in progress.
    if (acc && s_axis_tuser) begin
      state_d = ST_HUNT;
      buf_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_HUNT;
      mvld_q    <= '0;
      tvalid_q  <= 1'b0;
      rd_op_q   <= 8'd1;
      wr_op_q   <= 8'd2;
      call_op_q <= 8'd3;
      err_op_q  <= 8'd255;
      bad_q     <= 8'd1;
      unk_q     <= 8'd2;
    end else begin
      state_q <= state_d;
      mvld_q  <= mvld_d;
      if (emit && out_free) begin
        tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        tvalid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_READ_OP:   rd_op_q   <= cfg_data_i;
          REG_WRITE_OP:  wr_op_q   <= cfg_data_i;
          REG_CALL_OP:   call_op_q <= cfg_data_i;
          REG_ERROR_OP:  err_op_q  <= cfg_data_i;
          REG_BAD_PARAM: bad_q     <= cfg_data_i;
          REG_UNK_FUNC:  unk_q     <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d; id_q <= id_d; cmd_q <= cmd_d; sum_q <= sum_d;
    first_q <= first_d; ck_q <= ck_d; cnt_q <= cnt_d; idx_q <= idx_d;
    rep_n_q <= rep_n_d; rep_cmd_q <= rep_cmd_d; code_q <= code_d;
    rep_rd_q <= rep_rd_d; oor_q <= oor_d; maddr_q <= maddr_d; waddr_q <= waddr_d;
    if (emit && out_free) begin
      tdata_q <= emit_byte;
      tlast_q <= emit_last;
    end
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;

  a_last_is_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == REPLY_CLOSE)
    else $error("last beat of a reply is not a closing brace");

  a_mem_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> state_q == ST_WR_C && !oor_q)
    else $error("memory written outside a write pair");

  a_reply_needs_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OPEN && $past(state_q) != ST_OPEN |-> id_q != 8'd0)
    else $error("reply started for a frame with id zero");

  a_no_input_during_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> !s_axis_tready)
    else $error("input taken while a reply is being sent");

endmodule

// ----- sim/tb_framed_memory_command_responder.sv -----
// ----------------------------------------------------------------------------
// tb_framed_memory_command_responder
// Self-checking bench: sends command frames and noise on the input stream,
// predicts every reply byte with a model of the parser, command engine and
// memory, and compares the output stream beat by beat.
// ----------------------------------------------------------------------------
module tb_framed_memory_command_responder;
  import fmcr_pkg::*;

  typedef enum logic [2:0] {
    P_HUNT, P_LEN, P_ID, P_CMD, P_DATA, P_SUM, P_END
  } phase_e;

  typedef struct packed {
    logic [7:0] rx;
    logic       gap;
  } rx_beat_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
  } tx_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = '0;
  logic       s_axis_tuser = 1'b0;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  framed_memory_command_responder u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor state.
  logic [7:0] op_read, op_write, op_call, op_error, code_bad, code_unk;
  phase_e     ph;
  logic [7:0] len_data, fid, fcmd, rsum;
  int         dcnt;
  logic [7:0] dbuf [DATA_MAX];
  logic [7:0] mem  [MEMORY_DEPTH];

  rx_beat_t pending_rx[$];
  tx_beat_t reply_bytes[$];
  int       errors = 0;
  int       frames_sent = 0;
  int       replies_seen = 0;
  bit       hold_send = 1'b0;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task automatic push_reply(input logic [7:0] cmd, input logic [7:0] body[$]);
    logic [7:0] s;
    logic [7:0] ln;
    ln = 8'(6 + body.size());
    s = ln + fid + cmd;
    reply_bytes.push_back('{REPLY_OPEN, 1'b0});
    reply_bytes.push_back('{ln, 1'b0});
    reply_bytes.push_back('{fid, 1'b0});
    reply_bytes.push_back('{cmd, 1'b0});
    foreach (body[i]) begin
      reply_bytes.push_back('{body[i], 1'b0});
      s += body[i];
    end
    reply_bytes.push_back('{8'hFF - s, 1'b0});
    reply_bytes.push_back('{REPLY_CLOSE, 1'b1});
  endtask

  task automatic run_command();
    logic [7:0] body[$];
    int cnt;
    body = {};
    cnt = 0;
    if (fcmd == op_read) begin
      if (fid == 0) return;
      if (len_data == 0) begin
        body.push_back(code_bad);
        push_reply(op_error, body);
        return;
      end
      for (int i = 0; i < len_data && i < DATA_MAX; i++)
        body.push_back(dbuf[i] < MEMORY_DEPTH ? mem[dbuf[i]] : OUT_OF_RANGE);
      push_reply(op_read, body);
    end else if (fcmd == op_write) begin
      if (len_data == 0 || len_data[0]) begin
        if (fid != 0) begin
          body.push_back(code_bad);
          push_reply(op_error, body);
        end
        return;
      end
      for (int i = 0; i + 1 < len_data && i + 1 < DATA_MAX; i += 2)
        if (dbuf[i] < MEMORY_DEPTH) begin
          mem[dbuf[i]] = dbuf[i+1];
          cnt++;
        end
      if (fid == 0) return;
      body.push_back(8'(cnt));
      push_reply(op_write, body);
    end else if (fcmd == op_call) begin
      if (fid == 0) return;
      body.push_back((len_data == 0 || dbuf[0] >= FUNCTION_SLOTS) ? code_bad : code_unk);
      push_reply(op_error, body);
    end
  endtask

  task automatic predict_byte(input rx_beat_t b);
    if (b.gap) begin
      ph = P_HUNT;
      return;
    end
    case (ph)
      P_HUNT: if (b.rx == FRAME_OPEN) ph = P_LEN;
      P_LEN: begin
        len_data = (b.rx >= HEAD_BYTES) ? b.rx - HEAD_BYTES : 8'd0;
        rsum = b.rx;
        ph = P_ID;
      end
      P_ID: begin
        fid = b.rx;
        rsum += b.rx;
        ph = P_CMD;
      end
      P_CMD: begin
        fcmd = b.rx;
        rsum += b.rx;
        dcnt = 0;
        ph = (len_data == 0) ? P_SUM : P_DATA;
      end
      P_DATA: begin
        if (dcnt >= DATA_MAX) ph = P_HUNT;
        else begin
          dbuf[dcnt] = b.rx;
          rsum += b.rx;
          dcnt++;
          if (dcnt >= len_data) ph = P_SUM;
        end
      end
      P_SUM: begin
        rsum += b.rx;
        ph = P_END;
      end
      default: begin
        ph = P_HUNT;
        if (b.rx == FRAME_CLOSE && rsum == SUM_GOOD) run_command();
      end
    endcase
  endtask

  // Driver: bursts of beats with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_byte(pending_rx.pop_front());
      end
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_rx.size() > 0 && !hold_send) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_rx[0].rx;
          s_axis_tuser  <= pending_rx[0].gap;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  int stall_mode = 0;
  int stall_cnt = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        tx_beat_t e;
        if (reply_bytes.size() == 0) report($sformatf("unexpected beat %h", m_axis_tdata));
        else begin
          e = reply_bytes.pop_front();
          if (m_axis_tdata !== e.tx)
            report($sformatf("tx_byte %h, want %h", m_axis_tdata, e.tx));
          if (m_axis_tlast !== e.last)
            report($sformatf("last_byte %b, want %b", m_axis_tlast, e.last));
          if (e.last) replies_seen++;
        end
      end
      if (stall_cnt == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_cnt = $urandom_range(5, 60);
      end else stall_cnt--;
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 1) == 1);
        2: m_axis_tready <= ($urandom_range(0, 4) == 0);
        default: m_axis_tready <= (stall_cnt % 3 != 0);
      endcase
    end
  end

  // Frame building helpers.
  task automatic add_frame(input logic [7:0] cmd, input logic [7:0] id,
                           input logic [7:0] d[$], input bit corrupt_sum,
                           input bit bad_end);
    logic [7:0] ln;
    logic [7:0] s;
    ln = 8'(6 + d.size());
    s = ln + id + cmd;
    foreach (d[i]) s += d[i];
    pending_rx.push_back('{FRAME_OPEN, 1'b0});
    pending_rx.push_back('{ln, 1'b0});
    pending_rx.push_back('{id, 1'b0});
    pending_rx.push_back('{cmd, 1'b0});
    foreach (d[i]) pending_rx.push_back('{d[i], 1'b0});
    pending_rx.push_back('{(8'hFF - s) ^ {7'd0, corrupt_sum}, 1'b0});
    pending_rx.push_back('{bad_end ? 8'h5C : FRAME_CLOSE, 1'b0});
    frames_sent++;
  endtask

  task automatic drain();
    wait (pending_rx.size() == 0 && !s_axis_tvalid);
    wait (reply_bytes.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_cfg(input reg_idx_e idx, input logic [7:0] v);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_READ_OP:   op_read  = v;
      REG_WRITE_OP:  op_write = v;
      REG_CALL_OP:   op_call  = v;
      REG_ERROR_OP:  op_error = v;
      REG_BAD_PARAM: code_bad = v;
      default:       code_unk = v;
    endcase
  endtask

  task automatic random_frames(input int nbytes);
    logic [7:0] d[$];
    logic [7:0] cmd;
    int start, n, k;
    start = pending_rx.size();
    while (pending_rx.size() - start < nbytes) begin
      k = $urandom_range(0, 9);
      d = {};
      case ($urandom_range(0, 3))
        0: cmd = op_read;
        1: cmd = op_write;
        2: cmd = op_call;
        default: cmd = 8'($urandom);
      endcase
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DATA_MAX) : $urandom_range(0, 6);
      for (int i = 0; i < n; i++)
        d.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 70)));
      if (k < 7) add_frame(cmd, ($urandom_range(0, 6) == 0) ? 8'd0 : 8'($urandom), d,
                           1'b0, 1'b0);
      else if (k == 7) add_frame(cmd, 8'($urandom), d, $urandom_range(0, 1),
                                 $urandom_range(0, 1));
      else if (k == 8) begin
        pending_rx.push_back('{FRAME_OPEN, 1'b0});
        for (int i = $urandom_range(0, 5); i > 0; i--)
          pending_rx.push_back('{8'($urandom), 1'b0});
        pending_rx.push_back('{8'($urandom), 1'b1});
      end else
        for (int i = $urandom_range(1, 4); i > 0; i--)
          pending_rx.push_back('{8'($urandom), 1'($urandom)});
    end
  endtask

  initial begin
    logic [7:0] d[$];
    op_read = 1; op_write = 2; op_call = 3; op_error = 255; code_bad = 1; code_unk = 2;
    ph = P_HUNT; len_data = 0; fid = 0; fcmd = 0; rsum = 0; dcnt = 0;
    foreach (dbuf[i]) dbuf[i] = '0;
    foreach (mem[i]) mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: every command, zero data, short length, odd write, ranges.
    d = {8'd0, 8'd63, 8'd64, 8'd255}; add_frame(op_read, 8'd1, d, 0, 0);
    d = {8'd0, 8'hAA, 8'd63, 8'h55, 8'd200, 8'd1}; add_frame(op_write, 8'd255, d, 0, 0);
    d = {8'd0, 8'd63, 8'd64}; add_frame(op_read, 8'd7, d, 0, 0);
    d = {}; add_frame(op_read, 8'd2, d, 0, 0);
    d = {}; add_frame(op_write, 8'd3, d, 0, 0);
    d = {8'd5}; add_frame(op_write, 8'd3, d, 0, 0);
    d = {8'd15}; add_frame(op_call, 8'd4, d, 0, 0);
    d = {8'd16}; add_frame(op_call, 8'd4, d, 0, 0);
    d = {}; add_frame(op_call, 8'd4, d, 0, 0);
    d = {8'd1, 8'd9}; add_frame(op_write, 8'd0, d, 0, 0);
    d = {8'd1}; add_frame(op_read, 8'd0, d, 0, 0);
    d = {FRAME_OPEN}; add_frame(op_read, 8'd9, d, 0, 0);
    d = {8'd1}; add_frame(op_read, 8'd9, d, 1, 0);
    // Short length byte: frame parses with no data.
    pending_rx.push_back('{FRAME_OPEN, 1'b0});
    pending_rx.push_back('{8'd2, 1'b0});
    pending_rx.push_back('{8'd5, 1'b0});
    pending_rx.push_back('{8'd3, 1'b0});
    pending_rx.push_back('{8'hFF - 8'd10, 1'b0});
    pending_rx.push_back('{FRAME_CLOSE, 1'b0});
    // Overflow: length claims more data than the buffer holds.
    pending_rx.push_back('{FRAME_OPEN, 1'b0});
    pending_rx.push_back('{8'd60, 1'b0});
    pending_rx.push_back('{8'd1, 1'b0});
    pending_rx.push_back('{8'd1, 1'b0});
    for (int i = 0; i < DATA_MAX + 1; i++) pending_rx.push_back('{8'(i), 1'b0});
    d = {}; for (int i = 0; i < DATA_MAX; i++) d.push_back(8'(i * 2));
    add_frame(op_read, 8'd8, d, 0, 0);
    drain();

    // Pressure phase and config sweep, extremes included.
    write_cfg(REG_READ_OP, 8'd0);
    write_cfg(REG_WRITE_OP, 8'd255);
    write_cfg(REG_CALL_OP, 8'd128);
    write_cfg(REG_ERROR_OP, 8'd0);
    write_cfg(REG_BAD_PARAM, 8'd255);
    write_cfg(REG_UNK_FUNC, 8'd0);
    random_frames(70);
    drain();
    // Equal opcodes exercise the priority of read over write over call.
    write_cfg(REG_READ_OP, 8'd7);
    write_cfg(REG_WRITE_OP, 8'd7);
    write_cfg(REG_CALL_OP, 8'd7);
    write_cfg(REG_UNK_FUNC, 8'd255);
    random_frames(50);
    drain();
    write_cfg(REG_READ_OP, 8'd1);
    write_cfg(REG_WRITE_OP, 8'd2);
    write_cfg(REG_CALL_OP, 8'd3);
    write_cfg(REG_ERROR_OP, 8'd255);
    write_cfg(REG_BAD_PARAM, 8'd1);
    write_cfg(REG_UNK_FUNC, 8'd2);
    random_frames(100);
    drain();

    $display("covered %0d frames and noise; %0d replies checked", frames_sent, replies_seen);
    if (errors == 0 && reply_bytes.size() == 0) begin
      $display("[framed_memory_command_responder] OK");
    end else begin
      $display("[framed_memory_command_responder] ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("[framed_memory_command_responder] ERROR");
    $finish;
  end

endmodule
